FILE: rtl/core/bbq_pkg.sv
// Shared constants, codes and control types of the bandpass boost biquad.
package bbq_pkg;

	// Default sizes for the top level.
	localparam int MAX_CHAN_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 24;

	// Fixed-point layout.
	localparam int COEF_FRAC  = 28;
	localparam int EXTRA_FRAC = 16;
	localparam int BX_SHIFT   = COEF_FRAC - EXTRA_FRAC;
	localparam int WET_SHIFT  = COEF_FRAC + EXTRA_FRAC;
	// Low part of the filter state taken by one partial product.
	localparam int SPLIT      = 24;
	// Widest coefficient-side operand: target minus boost.
	localparam int COEF_A_W   = 33;
	// Unsigned 29-bit coefficients seen as signed operands.
	localparam int RAMP_BW    = 30;
	localparam int BOOST_W    = 32;
	// Wide enough to hold the largest clamped channel count.
	localparam int COUNT_W    = 7;

	// Configuration register widths and indexes.
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int B0_W      = 29;
	localparam int A1_W      = 31;
	localparam int A2_W      = 30;
	localparam int TGT_W     = 31;
	localparam int RAMP_W    = 29;
	localparam int CC_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TGT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CC   = 3'd5;

	localparam logic [RAMP_W-1:0] RAMP_RESET = 29'h1000_0000;
	localparam logic [CC_W-1:0]   CC_RESET   = 6'd2;

	// Operand selections of the shared multiplier.
	localparam int MUL_SEL_W = 3;
	localparam logic [MUL_SEL_W-1:0] MUL_RAMP  = 3'd0;
	localparam logic [MUL_SEL_W-1:0] MUL_BX    = 3'd1;
	localparam logic [MUL_SEL_W-1:0] MUL_A1_LO = 3'd2;
	localparam logic [MUL_SEL_W-1:0] MUL_A1_HI = 3'd3;
	localparam logic [MUL_SEL_W-1:0] MUL_A2_LO = 3'd4;
	localparam logic [MUL_SEL_W-1:0] MUL_A2_HI = 3'd5;
	localparam logic [MUL_SEL_W-1:0] MUL_BO_LO = 3'd6;
	localparam logic [MUL_SEL_W-1:0] MUL_BO_HI = 3'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 accept;
		logic                 mul_en;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 acc_en;
		logic                 boost_en;
		logic                 filt_en;
		logic                 d1_en;
		logic                 wr_en;
		logic                 out_en;
	} bbq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_start;
	} bbq_status_t;

endpackage

FILE: rtl/core/bbq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bbq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/bbq_ctrl.sv
// Sequencer that steps the shared multiplier through one item.
module bbq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bbq_pkg::bbq_status_t status,
	output bbq_pkg::bbq_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RAMP_M = 4'd1;
	localparam logic [3:0] S_RAMP_A = 4'd2;
	localparam logic [3:0] S_BX_M   = 4'd3;
	localparam logic [3:0] S_FILT   = 4'd4;
	localparam logic [3:0] S_A1_LO  = 4'd5;
	localparam logic [3:0] S_A1_HI  = 4'd6;
	localparam logic [3:0] S_A1_SUM = 4'd7;
	localparam logic [3:0] S_A2_HI  = 4'd8;
	localparam logic [3:0] S_A2_SUM = 4'd9;
	localparam logic [3:0] S_BO_HI  = 4'd10;
	localparam logic [3:0] S_BO_SUM = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands for each step.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = status.frame_start ? S_RAMP_M : S_BX_M;
				end
			end
			S_RAMP_M: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_RAMP;
				state_d     = S_RAMP_A;
			end
			S_RAMP_A: begin
				cmd.boost_en = 1'b1;
				state_d      = S_BX_M;
			end
			S_BX_M: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_BX;
				state_d     = S_FILT;
			end
			S_FILT: begin
				cmd.filt_en = 1'b1;
				state_d     = S_A1_LO;
			end
			S_A1_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_A1_LO;
				state_d     = S_A1_HI;
			end
			S_A1_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_A1_HI;
				cmd.acc_en  = 1'b1;
				state_d     = S_A1_SUM;
			end
			S_A1_SUM: begin
				cmd.d1_en   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_A2_LO;
				state_d     = S_A2_HI;
			end
			S_A2_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_A2_HI;
				cmd.acc_en  = 1'b1;
				state_d     = S_A2_SUM;
			end
			S_A2_SUM: begin
				cmd.wr_en   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_BO_LO;
				state_d     = S_BO_HI;
			end
			S_BO_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = bbq_pkg::MUL_BO_HI;
				cmd.acc_en  = 1'b1;
				state_d     = S_BO_SUM;
			end
			S_BO_SUM: begin
				// Wait here until the output register can take the item.
				if (slot_free) begin
					cmd.out_en = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_en |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting result");

	// Every accepted item starts its multiply sequence in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_RAMP_M || state_q == S_BX_M))
		else $error("accepted item did not start");

	// A frame start always takes the boost ramp step.
	a_frame_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && status.frame_start) |=> (state_q == S_RAMP_M))
		else $error("frame start skipped the boost ramp");

	// A new result appears only right after the final sum step.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_BO_SUM))
		else $error("result valid without a final sum step");

endmodule

FILE: rtl/core/bbq_datapath.sv
// Registers, channel counter, delay store and shared multiplier of the biquad.
module bbq_datapath #(
	parameter int MAX_CHAN    = bbq_pkg::MAX_CHAN_DEF,
	parameter int SAMPLE_BITS = bbq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bbq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bbq_pkg::CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  logic                                block_end,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	output logic                                block_end_out,
	input  bbq_pkg::bbq_cmd_t                   cmd,
	output bbq_pkg::bbq_status_t                status
);

	localparam int DB = SAMPLE_BITS + bbq_pkg::EXTRA_FRAC;
	localparam int MB = (SAMPLE_BITS > bbq_pkg::RAMP_BW) ? SAMPLE_BITS : bbq_pkg::RAMP_BW;
	localparam int CA = bbq_pkg::COEF_A_W;
	localparam int PW = CA + MB;
	localparam int SW = CA + DB + 1;
	localparam int SV = SW + 1;
	localparam int CW = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
	localparam int NW = bbq_pkg::COUNT_W;

	// Saturate a wide value to the delay width.
	function automatic logic signed [DB-1:0] sat_d(input logic signed [SV-1:0] v);
		logic all1;
		logic all0;
		all1 = &v[SV-1:DB-1];
		all0 = ~|v[SV-1:DB-1];
		if (all1 || all0) begin
			return v[DB-1:0];
		end else if (v[SV-1]) begin
			return {1'b1, {(DB-1){1'b0}}};
		end else begin
			return {1'b0, {(DB-1){1'b1}}};
		end
	endfunction

	// Saturate a wide value to the sample width.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [SV-1:0] v);
		logic all1;
		logic all0;
		all1 = &v[SV-1:SAMPLE_BITS-1];
		all0 = ~|v[SV-1:SAMPLE_BITS-1];
		if (all1 || all0) begin
			return v[SAMPLE_BITS-1:0];
		end else if (v[SV-1]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

	// Saturate a wide value to the boost width.
	function automatic logic signed [bbq_pkg::BOOST_W-1:0] sat_b(input logic signed [SV-1:0] v);
		logic all1;
		logic all0;
		all1 = &v[SV-1:bbq_pkg::BOOST_W-1];
		all0 = ~|v[SV-1:bbq_pkg::BOOST_W-1];
		if (all1 || all0) begin
			return v[bbq_pkg::BOOST_W-1:0];
		end else if (v[SV-1]) begin
			return {1'b1, {(bbq_pkg::BOOST_W-1){1'b0}}};
		end else begin
			return {1'b0, {(bbq_pkg::BOOST_W-1){1'b1}}};
		end
	endfunction

	// Configuration registers.
	logic [bbq_pkg::B0_W-1:0]          b0_q;
	logic signed [bbq_pkg::A1_W-1:0]   a1_q;
	logic signed [bbq_pkg::A2_W-1:0]   a2_q;
	logic signed [bbq_pkg::TGT_W-1:0]  tgt_q;
	logic [bbq_pkg::RAMP_W-1:0]        ramp_q;
	logic [bbq_pkg::CC_W-1:0]          cc_q;

	// Item state.
	logic signed [bbq_pkg::BOOST_W-1:0] boost_q;
	logic [CW-1:0]                      ci_q;
	logic [CW-1:0]                      ch_q;
	logic [MAX_CHAN-1:0]                vld_q;
	logic signed [SAMPLE_BITS-1:0]      x_q;
	logic                               be_q;
	logic signed [PW-1:0]               p_q;
	logic signed [SW-1:0]               acc_q;
	logic signed [DB-1:0]               filt_q;
	logic signed [PW:0]                 bxn_q;
	logic signed [DB-1:0]               d1n_q;
	logic signed [SAMPLE_BITS-1:0]      sample_out_q;
	logic                               block_end_out_q;

	// Combinational values.
	logic [NW-1:0]               cnt;
	logic [NW-1:0]               ci_ext;
	logic [NW-1:0]               eff;
	logic [NW-1:0]               nxt;
	logic signed [CA-1:0]        mul_a;
	logic signed [MB-1:0]        mul_b;
	logic signed [PW-1:0]        prod;
	logic signed [PW:0]          negbx;
	logic signed [SW-1:0]        full_sum;
	logic signed [SW-1:0]        q28;
	logic [2*DB-1:0]             rdata;
	logic                        dv;
	logic signed [DB-1:0]        d1_rd;
	logic signed [DB-1:0]        d2_rd;
	logic signed [DB-1:0]        d2_new;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q   <= '0;
			a1_q   <= '0;
			a2_q   <= '0;
			tgt_q  <= '0;
			ramp_q <= bbq_pkg::RAMP_RESET;
			cc_q   <= bbq_pkg::CC_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bbq_pkg::REG_B0:   b0_q   <= cfg_data[bbq_pkg::B0_W-1:0];
				bbq_pkg::REG_A1:   a1_q   <= cfg_data[bbq_pkg::A1_W-1:0];
				bbq_pkg::REG_A2:   a2_q   <= cfg_data[bbq_pkg::A2_W-1:0];
				bbq_pkg::REG_TGT:  tgt_q  <= cfg_data[bbq_pkg::TGT_W-1:0];
				bbq_pkg::REG_RAMP: ramp_q <= cfg_data[bbq_pkg::RAMP_W-1:0];
				bbq_pkg::REG_CC:   cc_q   <= cfg_data[bbq_pkg::CC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Channel count clamp and the channel of the next item.
	always_comb begin
		if (cc_q == '0) begin
			cnt = NW'(1);
		end else if (NW'(cc_q) > NW'(MAX_CHAN)) begin
			cnt = NW'(MAX_CHAN);
		end else begin
			cnt = NW'(cc_q);
		end
		ci_ext = NW'(ci_q);
		eff    = (ci_ext >= cnt) ? '0 : ci_ext;
		nxt    = ((eff + NW'(1)) >= cnt) ? '0 : (eff + NW'(1));
	end

	assign status.frame_start = (eff == '0);

	// Operand selection of the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			bbq_pkg::MUL_RAMP: begin
				mul_a = CA'(tgt_q) - CA'(boost_q);
				mul_b = MB'({1'b0, ramp_q});
			end
			bbq_pkg::MUL_BX: begin
				mul_a = CA'({1'b0, b0_q});
				mul_b = MB'(x_q);
			end
			bbq_pkg::MUL_A1_LO: begin
				mul_a = CA'(a1_q);
				mul_b = MB'({1'b0, filt_q[bbq_pkg::SPLIT-1:0]});
			end
			bbq_pkg::MUL_A1_HI: begin
				mul_a = CA'(a1_q);
				mul_b = MB'(signed'(filt_q[DB-1:bbq_pkg::SPLIT]));
			end
			bbq_pkg::MUL_A2_LO: begin
				mul_a = CA'(a2_q);
				mul_b = MB'({1'b0, filt_q[bbq_pkg::SPLIT-1:0]});
			end
			bbq_pkg::MUL_A2_HI: begin
				mul_a = CA'(a2_q);
				mul_b = MB'(signed'(filt_q[DB-1:bbq_pkg::SPLIT]));
			end
			bbq_pkg::MUL_BO_LO: begin
				mul_a = CA'(boost_q);
				mul_b = MB'({1'b0, filt_q[bbq_pkg::SPLIT-1:0]});
			end
			bbq_pkg::MUL_BO_HI: begin
				mul_a = CA'(boost_q);
				mul_b = MB'(signed'(filt_q[DB-1:bbq_pkg::SPLIT]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// Delay values read back; entries never written read as zero.
	assign dv    = vld_q[ch_q];
	assign d1_rd = dv ? signed'(rdata[2*DB-1:DB]) : '0;
	assign d2_rd = dv ? signed'(rdata[DB-1:0]) : '0;

	// Partial product sum: low part accumulated, high part shifted in.
	assign full_sum = acc_q + (SW'(p_q) <<< bbq_pkg::SPLIT);
	assign q28      = full_sum >>> bbq_pkg::COEF_FRAC;
	assign negbx    = -((PW+1)'(p_q));
	assign d2_new   = sat_d(SV'(bxn_q) - SV'(q28));

	// Channel state, delay valid bits and boost level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q    <= '0;
			vld_q   <= '0;
			boost_q <= '0;
		end else begin
			if (cmd.accept) begin
				ci_q <= nxt[CW-1:0];
			end
			if (cmd.wr_en) begin
				vld_q[ch_q] <= 1'b1;
			end
			if (cmd.boost_en) begin
				boost_q <= sat_b(SV'(boost_q) + SV'(p_q >>> bbq_pkg::COEF_FRAC));
			end
		end
	end

	// Arithmetic pipeline registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q  <= sample_in;
			be_q <= block_end;
			ch_q <= eff[CW-1:0];
		end
		if (cmd.mul_en) begin
			p_q <= prod;
		end
		if (cmd.acc_en) begin
			acc_q <= SW'(p_q);
		end
		if (cmd.filt_en) begin
			filt_q <= sat_d(SV'(p_q >>> bbq_pkg::BX_SHIFT) + SV'(d1_rd));
			bxn_q  <= negbx >>> bbq_pkg::BX_SHIFT;
		end
		if (cmd.d1_en) begin
			d1n_q <= sat_d(SV'(d2_rd) - SV'(q28));
		end
		if (cmd.out_en) begin
			sample_out_q    <= sat_s(SV'(x_q) + SV'(full_sum >>> bbq_pkg::WET_SHIFT));
			block_end_out_q <= be_q;
		end
	end

	// Per-channel delay store: first and second delay side by side.
	bbq_ram #(
		.WIDTH(2 * DB),
		.DEPTH(MAX_CHAN)
	) u_delay_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (ch_q),
		.wdata ({d1n_q, d2_new}),
		.re    (cmd.accept),
		.raddr (eff[CW-1:0]),
		.rdata (rdata)
	);

	assign sample_out    = sample_out_q;
	assign block_end_out = block_end_out_q;

endmodule

FILE: rtl/core/bandpass_boost_biquad.sv
// The block takes one item at a time: a new item is accepted only once the previous one
// has been loaded into the output register, which waits while a result is held. The single
// shared multiplier runs seven products in sequence, eight at a frame start (boost ramp
// at a frame start only, feedforward, three filter-state products split in two halves each).
// Reset: asynchronous, active low; clears boost, channel counter, delay valid bits,
// handshake state and loads the register reset values.
module bandpass_boost_biquad #(
	parameter int MAX_CHAN    = bbq_pkg::MAX_CHAN_DEF,
	parameter int SAMPLE_BITS = bbq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bbq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbq_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          block_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          block_end_out
);

	bbq_pkg::bbq_cmd_t    cmd;
	bbq_pkg::bbq_status_t status;

	// Step sequencer.
	bbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic, registers and delay store.
	bbq_datapath #(
		.MAX_CHAN    (MAX_CHAN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_in     (sample_in),
		.block_end     (block_end),
		.sample_out    (sample_out),
		.block_end_out (block_end_out),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the bandpass boost biquad with a bit-exact filter predictor.
`timescale 1ns / 1ps

module testbench;
	import bbq_pkg::*;

	localparam int SW  = SAMPLE_BITS_DEF;
	localparam int DW  = SAMPLE_BITS_DEF + EXTRA_FRAC;
	localparam int NCH = MAX_CHAN_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 14;

	// Register indexes that no register answers to.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic signed [SW-1:0] LEVEL_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] LEVEL_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [SW-1:0] level;
		logic                 marker;
	} boosted_t;

	// Tracks the filter state of every channel and the boosted samples still owed.
	class boost_ledger;
		logic        [B0_W-1:0]   b0;
		logic signed [A1_W-1:0]   fb_one;
		logic signed [A2_W-1:0]   fb_two;
		logic signed [TGT_W-1:0]  tgt;
		logic        [RAMP_W-1:0] ramp;
		logic        [CC_W-1:0]   chan_count;
		logic signed [BOOST_W-1:0] boost;
		logic signed [DW-1:0]     delay_one [NCH];
		logic signed [DW-1:0]     delay_two [NCH];
		int                       chan;
		boosted_t                 pending_out [$];
		int                       failures;

		function new();
			b0 = '0;
			fb_one = '0;
			fb_two = '0;
			tgt = '0;
			ramp = RAMP_RESET;
			chan_count = CC_RESET;
			boost = '0;
			chan = 0;
			failures = 0;
			for (int i = 0; i < NCH; i++) begin
				delay_one[i] = '0;
				delay_two[i] = '0;
			end
		endfunction

		// Product of two operands, floored after dropping sh fraction bits.
		function wide_t mul_floor(wide_t a, wide_t b, int sh);
			wide_t p;
			p = a * b;
			return p >>> sh;
		endfunction

		function wide_t clamp(wide_t v, int w);
			wide_t top, bottom;
			top = wide_t'(1);
			top = (top <<< (w - 1)) - 1;
			bottom = -top - 1;
			if (v > top)
				return top;
			if (v < bottom)
				return bottom;
			return v;
		endfunction

		// Registers keep only their own width; signed ones are sign-extended.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_B0: b0 = data[B0_W-1:0];
				REG_A1: fb_one = data[A1_W-1:0];
				REG_A2: fb_two = data[A2_W-1:0];
				REG_TGT: tgt = data[TGT_W-1:0];
				REG_RAMP: ramp = data[RAMP_W-1:0];
				REG_CC: chan_count = data[CC_W-1:0];
				default: ;
			endcase
		endfunction

		// Runs one accepted sample through its channel and queues the boosted result.
		function void take_sample(logic signed [SW-1:0] level, logic marker);
			int       lanes;
			wide_t    x, bx, filt, acc, wet;
			boosted_t item;
			lanes = int'(chan_count);
			if (lanes == 0)
				lanes = 1;
			if (lanes > NCH)
				lanes = NCH;
			if (chan >= lanes)
				chan = 0;

			// A frame start moves the boost one step toward its target.
			if (chan == 0) begin
				acc = wide_t'(tgt);
				acc = acc - wide_t'(boost);
				acc = wide_t'(boost) + mul_floor(wide_t'(ramp), acc, COEF_FRAC);
				boost = BOOST_W'(clamp(acc, BOOST_W));
			end

			x = wide_t'(level);
			bx = wide_t'(b0);
			bx = bx * x;
			acc = bx >>> BX_SHIFT;
			acc = acc + wide_t'(delay_one[chan]);
			filt = clamp(acc, DW);
			acc = wide_t'(delay_two[chan]);
			acc = acc - mul_floor(wide_t'(fb_one), filt, COEF_FRAC);
			delay_one[chan] = DW'(clamp(acc, DW));
			acc = -bx;
			acc = acc >>> BX_SHIFT;
			acc = acc - mul_floor(wide_t'(fb_two), filt, COEF_FRAC);
			delay_two[chan] = DW'(clamp(acc, DW));

			wet = mul_floor(wide_t'(boost), filt, COEF_FRAC) >>> EXTRA_FRAC;
			acc = x + wet;
			item.level = SW'(clamp(acc, SW));
			item.marker = marker;
			pending_out.push_back(item);
			chan = (chan + 1 >= lanes) ? 0 : chan + 1;
		endfunction

		// Compares one delivered item with the oldest expected one.
		function void check_output(logic signed [SW-1:0] level, logic marker);
			boosted_t want;
			if (pending_out.size() == 0) begin
				failures++;
				$display("%0t: unexpected output item: expected none, got sample_out %0d block_end_out %0b",
					$time, level, marker);
				return;
			end
			want = pending_out.pop_front();
			if (level !== want.level) begin
				failures++;
				$display("%0t: sample_out mismatch: expected %0d, got %0d", $time, want.level, level);
			end
			if (marker !== want.marker) begin
				failures++;
				$display("%0t: block_end_out mismatch: expected %0b, got %0b", $time, want.marker,
					marker);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [SW-1:0]  sample_in;
	logic                  block_end;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [SW-1:0]  sample_out;
	logic                  block_end_out;

	boost_ledger ledger = new();
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          jitter_on = 1'b0;

	bandpass_boost_biquad dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_in    (sample_in),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.block_end_out(block_end_out)
	);

	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Output side: random back-pressure while jitter is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!jitter_on || $urandom_range(0, 99) < 75) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			stall_left = idle_len() - 1;
		end
	end

	// Every accepted item on either side goes to the ledger.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			ledger.take_sample(sample_in, block_end);
		if (out_valid && out_ready)
			ledger.check_output(sample_out, block_end_out);
	end

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		ledger.write_reg(idx, data);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_all(input int b0v, input int a1v, input int a2v, input int tv,
			input int rv, input int cv);
		apply_reg(REG_B0, b0v[CFG_W-1:0]);
		apply_reg(REG_A1, a1v[CFG_W-1:0]);
		apply_reg(REG_A2, a2v[CFG_W-1:0]);
		apply_reg(REG_TGT, tv[CFG_W-1:0]);
		apply_reg(REG_RAMP, rv[CFG_W-1:0]);
		apply_reg(REG_CC, cv[CFG_W-1:0]);
	endtask

	// Holds valid until the item is taken; valid only drops when a gap is wanted.
	task automatic send_item(input logic signed [SW-1:0] level, input logic marker, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= level;
		block_end <= marker;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stops sending and waits until every owed item has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending_out.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 85)
			return $urandom_range(9, 32);
		if (r < 92)
			return 0;
		return $urandom_range(33, 63);
	endfunction

	function automatic logic signed [SW-1:0] next_level(input logic signed [SW-1:0] prev);
		int          r, v;
		logic [31:0] w;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			w = $urandom;
			return w[SW-1:0];
		end
		if (r < 85) begin
			v = $urandom_range(0, 32767);
			v -= 16384;
			return v[SW-1:0];
		end
		if (r < 93) begin
			case ($urandom_range(0, 3))
				0: return LEVEL_MAX;
				1: return LEVEL_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		return prev;
	endfunction

	// One filter setting per phase: a stable bandpass, corner values, or anything in range.
	task automatic pick_config(input int kind);
		int a2v, lim, a1v, b0v, tv, rv;
		case (kind)
			0: begin
				a2v = $urandom_range(0, 255013683);
				lim = (268435456 + a2v) / 10 * 9;
				a1v = $urandom_range(0, 2 * lim);
				a1v -= lim;
				b0v = (268435456 - a2v) / 2;
				tv = $urandom_range(0, 1342177279);
				tv -= 268435456;
				rv = $urandom_range(0, 268435456);
			end
			1: begin
				b0v = $urandom_range(0, 1) ? 268435456 : 0;
				a1v = $urandom_range(0, 1) ? 536870912 : -536870912;
				a2v = $urandom_range(0, 1) ? 268435456 : -268435456;
				tv = $urandom_range(0, 1) ? 1073741823 : -268435456;
				case ($urandom_range(0, 2))
					0: rv = 0;
					1: rv = 268435456;
					default: rv = 536870911;
				endcase
			end
			default: begin
				b0v = $urandom_range(0, 268435456);
				a1v = $urandom_range(0, 1073741824);
				a1v -= 536870912;
				a2v = $urandom_range(0, 536870912);
				a2v -= 268435456;
				tv = $urandom_range(0, 1342177279);
				tv -= 268435456;
				rv = $urandom_range(0, 536870911);
			end
		endcase
		set_all(b0v, a1v, a2v, tv, rv, pick_count());
	endtask

	initial begin
		logic signed [SW-1:0] lvl;
		int                   gap;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		block_end = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero feedforward and zero boost pass the input straight through.
		send_item(LEVEL_MAX, 1'b0, 0);
		send_item(LEVEL_MIN, 1'b1, 0);
		send_item('0, 1'b0, 0);
		send_item('1, 1'b1, 0);
		send_item(24'sd1, 1'b0, 2);
		send_item(24'sh555555, 1'b1, 0);
		send_item(24'shAAAAAA, 1'b0, 0);
		settle();

		// Full feedforward and the largest boost drive the output into saturation.
		set_all(268435456, 0, 0, 1073741823, 268435456, 1);
		send_item(LEVEL_MAX, 1'b0, 0);
		send_item(LEVEL_MIN, 1'b1, 0);
		send_item(24'sd4096, 1'b0, 0);
		send_item(-24'sd4096, 1'b1, 0);
		settle();

		// Writes to unused indexes must change nothing; a count of zero means one channel;
		// a ramp above unity overshoots; stray high bits of b0 are dropped.
		apply_reg(REG_SPARE_LO, '1);
		apply_reg(REG_SPARE_HI, '1);
		apply_reg(REG_B0, {2'b11, 29'h1000_0000});
		apply_reg(REG_A1, -31'sd536870912);
		apply_reg(REG_A2, 31'sd268435456);
		apply_reg(REG_TGT, -31'sd268435456);
		apply_reg(REG_RAMP, 31'd536870911);
		apply_reg(REG_CC, 31'd0);
		send_item(LEVEL_MAX, 1'b0, 0);
		send_item(24'sh123456, 1'b0, 0);
		send_item(LEVEL_MIN, 1'b1, 0);
		settle();

		// A count above the channel store is clamped; a zero ramp freezes the boost.
		set_all(268435456, 536870912, -268435456, 0, 0, 40);
		send_item(LEVEL_MIN, 1'b0, 0);
		send_item(LEVEL_MAX, 1'b1, 0);
		send_item(24'sh0F0F0F, 1'b0, 0);
		settle();

		// Lowering the count mid-frame restarts the counter at a frame start.
		set_all(134217728, -268435456, 134217728, 536870912, 134217728, 4);
		send_item(24'sh400000, 1'b0, 0);
		send_item(-24'sh400000, 1'b0, 0);
		settle();
		apply_reg(REG_CC, 31'd1);
		send_item(24'sh200000, 1'b0, 0);
		send_item(24'sh7FF000, 1'b1, 0);
		settle();

		// Random phases, each with a fresh setting and a mid-phase count change.
		lvl = '0;
		for (int ph = 0; ph < 8; ph++) begin
			pick_config(ph % 3);
			for (int k = 0; k < 131; k++) begin
				if (k % 40 == 0)
					jitter_on = ($urandom_range(0, 3) != 0);
				if (k == 65) begin
					settle();
					apply_reg(REG_CC, CFG_W'(pick_count()));
				end
				gap = (jitter_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
				lvl = next_level(lvl);
				send_item(lvl, $urandom_range(0, 15) == 0, gap);
			end
			settle();
		end

		if (ledger.failures == 0 && ledger.pending_out.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
